>>> src/adc_key_short_long_press_core_defines.svh
// assertion macros of the adc key press core
`ifndef ADC_KEY_SHORT_LONG_PRESS_CORE_DEFINES_SVH
`define ADC_KEY_SHORT_LONG_PRESS_CORE_DEFINES_SVH

// clocked check, masked while reset is high
`define ADCKEY_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define ADCKEY_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/adckey_pkg.sv
// shared constants and types of the adc key press detector
package adckey_pkg;

  localparam int NKEYS          = 8;
  localparam int NCH            = 4;
  localparam int ADC_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF = 10;

  localparam int THR_W     = 12;
  localparam int LIM_W     = 10;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_LIMIT = 2'd2;

  localparam logic [THR_W-1:0] LOW_THR_RST  = 12'd200;
  localparam logic [THR_W-1:0] HIGH_THR_RST = THR_W'(4095 - 500);
  localparam logic [LIM_W-1:0] LIMIT_RST    = 10'd30;

  typedef struct packed {
    logic [NKEYS-1:0] short_press;
    logic [NKEYS-1:0] long_hold;
    logic [NKEYS-1:0] pressed;
  } key_result_t;

endpackage

>>> src/adckey_if.sv
// valid/ready channels for adc samples and key press results
interface adckey_sample_if #(
  parameter int ADC_BITS = adckey_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                scan_tick;
  logic [ADC_BITS-1:0] sample_ch0;
  logic [ADC_BITS-1:0] sample_ch1;
  logic [ADC_BITS-1:0] sample_ch2;
  logic [ADC_BITS-1:0] sample_ch3;

  modport source (
    output valid, scan_tick, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    input  ready
  );
  modport sink (
    input  valid, scan_tick, sample_ch0, sample_ch1, sample_ch2, sample_ch3,
    output ready
  );
endinterface

interface adckey_result_if;
  logic                         valid;
  logic                         ready;
  logic [adckey_pkg::NKEYS-1:0] short_press_mask;
  logic [adckey_pkg::NKEYS-1:0] long_hold_mask;
  logic [adckey_pkg::NKEYS-1:0] pressed_mask;

  modport source (
    output valid, short_press_mask, long_hold_mask, pressed_mask,
    input  ready
  );
  modport sink (
    input  valid, short_press_mask, long_hold_mask, pressed_mask,
    output ready
  );
endinterface

>>> src/adckey_eval.sv
// per-key threshold compare, hold counter update and press classification
module adckey_eval #(
  parameter int ADC_BITS   = adckey_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = adckey_pkg::COUNT_BITS_DEF
) (
  input  logic                                scan_tick,
  input  logic [ADC_BITS-1:0]                 samples [adckey_pkg::NCH],
  input  logic [adckey_pkg::THR_W-1:0]        low_thr,
  input  logic [adckey_pkg::THR_W-1:0]        high_thr,
  input  logic [adckey_pkg::LIM_W-1:0]        limit,
  input  logic [adckey_pkg::NKEYS-1:0]        pressed_prev,
  input  logic [COUNT_BITS-1:0]               hold_count [adckey_pkg::NKEYS],
  output logic [COUNT_BITS-1:0]               hold_next  [adckey_pkg::NKEYS],
  output adckey_pkg::key_result_t             result
);
  import adckey_pkg::*;

  localparam int CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;
  localparam int EL_W  = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;
  localparam logic [CMP_W-1:0] ADC_MASK  = CMP_W'((1 << ADC_BITS) - 1);
  localparam logic [EL_W-1:0]  COUNT_MAX = EL_W'((1 << COUNT_BITS) - 1);

  logic [CMP_W-1:0]      lo;
  logic [CMP_W-1:0]      hi;
  logic [EL_W-1:0]       lim_ext;
  logic [COUNT_BITS-1:0] eff_lim;
  logic [NKEYS-1:0]      now_pressed;
  logic [NKEYS-1:0]      pressed;

  assign lo      = CMP_W'(low_thr) & ADC_MASK;
  assign hi      = CMP_W'(high_thr) & ADC_MASK;
  assign lim_ext = EL_W'(limit);
  assign eff_lim = COUNT_BITS'((lim_ext > COUNT_MAX) ? COUNT_MAX : lim_ext);

  // a sample meeting both thresholds reads as the low key only
  always_comb begin
    logic [CMP_W-1:0] s;
    for (int ch = 0; ch < NCH; ch++) begin
      s = CMP_W'(samples[ch]);
      now_pressed[ch]       = (s <= lo);
      now_pressed[ch + NCH] = !(s <= lo) && (s >= hi);
    end
  end

  assign pressed = scan_tick ? now_pressed : pressed_prev;

  always_comb begin
    logic [COUNT_BITS-1:0] base;
    result.pressed = pressed;
    for (int k = 0; k < NKEYS; k++) begin
      base = (pressed[k] && !pressed_prev[k]) ? '0 : hold_count[k];
      if (scan_tick && pressed[k] && (base < eff_lim)) begin
        hold_next[k] = base + 1'b1;
      end else begin
        hold_next[k] = base;
      end
      result.short_press[k] = scan_tick && !pressed[k] && pressed_prev[k] &&
                              (hold_next[k] < eff_lim);
      result.long_hold[k]   = pressed[k] && (hold_next[k] >= eff_lim);
    end
  end

endmodule

>>> src/adc_key_short_long_press_core.sv
// top level of the adc keypad short and long press detector
//
//  channel  dir  payload                                         transfer when
//  samples  in   scan_tick, sample_ch0..sample_ch3               valid && ready
//  keys     out  short_press_mask, long_hold_mask, pressed_mask  valid && ready
//  cfg      in   cfg_index, cfg_wdata                            cfg_we
//
//  one item per cycle sustained while the result is taken; an item moves from the input
//  register through the eight compare-and-count updates into the result register,
//  with key state written as the result is loaded
//  reset restores the thresholds and limit, clears pressed state and hold counters
//  a stalled result holds the next item in the input register; ready drops only
//  when both registers are full and the result is not taken
module adc_key_short_long_press_core #(
  parameter int ADC_BITS   = adckey_pkg::ADC_BITS_DEF,
  parameter int COUNT_BITS = adckey_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [adckey_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adckey_pkg::CFG_W-1:0]     cfg_wdata,
  adckey_sample_if.sink                    samples,
  adckey_result_if.source                  keys
);
  import adckey_pkg::*;
  `include "adc_key_short_long_press_core_defines.svh"

  logic [THR_W-1:0] low_thr;
  logic [THR_W-1:0] high_thr;
  logic [LIM_W-1:0] limit;

  logic                s1_valid;
  logic                s1_tick;
  logic [ADC_BITS-1:0] s1_samples [NCH];
  logic                s1_adv;
  logic                in_xfer;

  logic                  out_valid;
  key_result_t           out_res;
  key_result_t           res;
  logic [NKEYS-1:0]      pressed_prev;
  logic [COUNT_BITS-1:0] hold_count [NKEYS];
  logic [COUNT_BITS-1:0] hold_next  [NKEYS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_thr  <= LOW_THR_RST;
      high_thr <= HIGH_THR_RST;
      limit    <= LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_THR:    low_thr  <= cfg_wdata[THR_W-1:0];
        REG_HIGH_THR:   high_thr <= cfg_wdata[THR_W-1:0];
        REG_LONG_LIMIT: limit    <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_adv        = s1_valid && (!out_valid || keys.ready);
  assign samples.ready = !s1_valid || s1_adv;
  assign in_xfer       = samples.valid && samples.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_tick       <= samples.scan_tick;
      s1_samples[0] <= samples.sample_ch0;
      s1_samples[1] <= samples.sample_ch1;
      s1_samples[2] <= samples.sample_ch2;
      s1_samples[3] <= samples.sample_ch3;
    end
  end

  adckey_eval #(
    .ADC_BITS   (ADC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .scan_tick    (s1_tick),
    .samples      (s1_samples),
    .low_thr      (low_thr),
    .high_thr     (high_thr),
    .limit        (limit),
    .pressed_prev (pressed_prev),
    .hold_count   (hold_count),
    .hold_next    (hold_next),
    .result       (res)
  );

  // result register and key state, both move as an item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      pressed_prev <= '0;
      for (int k = 0; k < NKEYS; k++) begin
        hold_count[k] <= '0;
      end
    end else if (s1_adv) begin
      out_valid    <= 1'b1;
      pressed_prev <= res.pressed;
      hold_count   <= hold_next;
    end else if (keys.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res;
    end
  end

  assign keys.valid            = out_valid;
  assign keys.short_press_mask = out_res.short_press;
  assign keys.long_hold_mask   = out_res.long_hold;
  assign keys.pressed_mask     = out_res.pressed;

  `ADCKEY_ASSERT(a_short_long_disjoint,
    out_valid |-> ((out_res.short_press & out_res.long_hold) == '0),
    "key reported short and long at once")
  `ADCKEY_ASSERT(a_short_released,
    out_valid |-> ((out_res.short_press & out_res.pressed) == '0),
    "short press on a key still pressed")
  `ADCKEY_ASSERT(a_long_pressed,
    out_valid |-> ((out_res.long_hold & ~out_res.pressed) == '0),
    "long hold on a released key")
  `ADCKEY_ASSERT(a_stall_keeps_item,
    (s1_valid && !s1_adv) |=> s1_valid,
    "stalled input item lost")
  `ADCKEY_ASSERT_ALWAYS(a_ready_only_when_full,
    !samples.ready |-> (s1_valid && out_valid && !keys.ready),
    "ready dropped with room available")

endmodule

>>> tb/sv/adc_key_short_long_press_core_tb.sv
// self-checking testbench of the adc keypad short and long press detector
module adc_key_short_long_press_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adckey_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {KEY_NONE, KEY_LOW, KEY_HIGH} key_pos_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  adckey_sample_if smp ();
  adckey_result_if res ();

  adc_key_short_long_press_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .samples   (smp),
    .keys      (res)
  );

  always #1 clk = ~clk;

  // predicted keypad state and settings
  logic [THR_W-1:0] low_thr     = LOW_THR_RST;
  logic [THR_W-1:0] high_thr    = HIGH_THR_RST;
  logic [LIM_W-1:0] press_limit = LIMIT_RST;
  logic [NKEYS-1:0] key_down    = '0;
  logic [LIM_W-1:0] hold_ticks [NKEYS] = '{default: '0};

  key_result_t pending_results [$];
  int          errors = 0;
  bit          quiet = 1'b0;
  int          stall_left = 0;

  // per-channel press plan for the random sequences
  key_pos_t chan_pos  [NCH] = '{default: KEY_NONE};
  int       chan_left [NCH] = '{default: 0};

  function automatic key_result_t step_keypad(input logic tick,
                                              input logic [THR_W-1:0] s0, s1, s2, s3);
    key_result_t      r;
    logic [THR_W-1:0] lvl [NCH];
    logic [NKEYS-1:0] down;
    r = '0;
    lvl = '{s0, s1, s2, s3};
    down = '0;
    if (!tick) begin
      for (int k = 0; k < NKEYS; k++)
        r.long_hold[k] = key_down[k] && (hold_ticks[k] >= press_limit);
      r.pressed = key_down;
      return r;
    end
    // a sample matching both thresholds reads as low only
    for (int c = 0; c < NCH; c++) begin
      if (lvl[c] <= low_thr) down[c] = 1'b1;
      else if (lvl[c] >= high_thr) down[c + NCH] = 1'b1;
    end
    for (int k = 0; k < NKEYS; k++) begin
      if (down[k] && !key_down[k]) hold_ticks[k] = '0;
      if (down[k] && hold_ticks[k] < press_limit) hold_ticks[k] = hold_ticks[k] + 1'b1;
      if (hold_ticks[k] < press_limit) r.short_press[k] = !down[k] && key_down[k];
      else r.long_hold[k] = down[k];
    end
    key_down = down;
    r.pressed = down;
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] d);
    case (idx)
      REG_LOW_THR:    low_thr = d;
      REG_HIGH_THR:   high_thr = d;
      REG_LONG_LIMIT: press_limit = d[LIM_W-1:0];
      default: ;
    endcase
  endfunction

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [THR_W-1:0] level_for(input key_pos_t pos);
    int lo_i;
    int hi_i;
    lo_i = low_thr;
    hi_i = high_thr;
    case (pos)
      KEY_LOW:  return THR_W'($urandom_range(0, lo_i));
      KEY_HIGH: return THR_W'($urandom_range(hi_i, 4095));
      default: begin
        if (hi_i - lo_i >= 2) return THR_W'($urandom_range(lo_i + 1, hi_i - 1));
        return THR_W'($urandom);
      end
    endcase
  endfunction

  task automatic send_scan(input logic tick, input logic [THR_W-1:0] s0, s1, s2, s3);
    int gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid      <= 1'b1;
    smp.scan_tick  <= tick;
    smp.sample_ch0 <= s0;
    smp.sample_ch1 <= s1;
    smp.sample_ch2 <= s2;
    smp.sample_ch3 <= s3;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    pending_results.push_back(step_keypad(tick, s0, s1, s2, s3));
  endtask

  // drain all outstanding results, then let the pipeline empty
  task automatic settle();
    smp.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic run_presses(input int n_items, input int max_hold, input int noise_pct,
                             input int no_tick_pct);
    logic [THR_W-1:0] s [NCH];
    logic             tick;
    for (int i = 0; i < n_items; i++) begin
      for (int c = 0; c < NCH; c++) begin
        if (chan_left[c] <= 0) begin
          chan_pos[c]  = key_pos_t'($urandom_range(0, 2));
          chan_left[c] = $urandom_range(1, max_hold);
        end
        s[c] = ($urandom_range(0, 99) < noise_pct) ? THR_W'($urandom) : level_for(chan_pos[c]);
      end
      tick = ($urandom_range(0, 99) >= no_tick_pct);
      if (tick)
        for (int c = 0; c < NCH; c++) chan_left[c]--;
      send_scan(tick, s[0], s[1], s[2], s[3]);
    end
  endtask

  task automatic test_thresholds();
    settle();
    // reset thresholds: at and just past each one
    send_scan(1'b1, 12'd200, 12'd201, 12'd3594, 12'd3595);
    send_scan(1'b1, 12'd0, 12'd4095, 12'd201, 12'd3594);
    send_scan(1'b0, 12'd4095, 12'd0, 12'd0, 12'd0);
    send_scan(1'b1, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    settle();
    // crossed thresholds, the low key wins
    write_reg(REG_LOW_THR, 12'd3000);
    write_reg(REG_HIGH_THR, 12'd1000);
    send_scan(1'b1, 12'd2000, 12'd500, 12'd3500, 12'd3000);
    settle();
    write_reg(REG_LOW_THR, 12'd0);
    write_reg(REG_HIGH_THR, 12'd4095);
    send_scan(1'b1, 12'd0, 12'd1, 12'd4094, 12'd4095);
    settle();
    write_reg(REG_LOW_THR, 12'd4095);
    write_reg(REG_HIGH_THR, 12'd0);
    send_scan(1'b1, 12'd4095, 12'd0, 12'hAAA, 12'h555);
    settle();
    write_reg(REG_LOW_THR, 12'd0);
    send_scan(1'b1, 12'd0, 12'd1, 12'd4095, 12'h800);
  endtask

  task automatic test_short_long();
    settle();
    write_reg(REG_LOW_THR, LOW_THR_RST);
    write_reg(REG_HIGH_THR, HIGH_THR_RST);
    write_reg(REG_LONG_LIMIT, 12'd3);
    send_scan(1'b1, 12'd0, 12'd4095, 12'd2048, 12'd2048);
    send_scan(1'b1, 12'd0, 12'd4095, 12'd2048, 12'd2048);
    send_scan(1'b1, 12'd2048, 12'd4095, 12'd0, 12'd2048);
    send_scan(1'b0, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    send_scan(1'b1, 12'd2048, 12'd4095, 12'd0, 12'd2048);
    // releases after the limit give neither pulse
    send_scan(1'b1, 12'd2048, 12'd2048, 12'd0, 12'd2048);
    send_scan(1'b1, 12'd4095, 12'd2048, 12'd2048, 12'd2048);
    send_scan(1'b1, 12'd0, 12'd2048, 12'd2048, 12'd2048);
  endtask

  task automatic test_limit_edges();
    settle();
    // upper bits of the write fall away, leaving a limit of zero
    write_reg(REG_LONG_LIMIT, 12'hC00);
    send_scan(1'b1, 12'd0, 12'd0, 12'd4095, 12'd2048);
    send_scan(1'b1, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    settle();
    write_reg(REG_LONG_LIMIT, 12'd1);
    send_scan(1'b1, 12'd0, 12'd2048, 12'd2048, 12'd4095);
    settle();
    // long hold is worked out again from state under the new limit
    write_reg(REG_LONG_LIMIT, 12'hFFF);
    send_scan(1'b0, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
    settle();
    write_reg(REG_LONG_LIMIT, 12'd0);
    write_reg(REG_UNUSED, 12'hFFF);
    send_scan(1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
    send_scan(1'b1, 12'd0, 12'd2048, 12'd2048, 12'd2048);
  endtask

  task automatic test_random_settings();
    logic [THR_W-1:0] lo;
    logic [THR_W-1:0] hi;
    logic [LIM_W-1:0] lim;
    int               r;
    for (int p = 0; p < 5; p++) begin
      settle();
      if ($urandom_range(0, 99) < 80) begin
        lo = THR_W'($urandom_range(0, 1500));
        hi = THR_W'($urandom_range(2500, 4095));
      end else begin
        lo = THR_W'($urandom);
        hi = THR_W'($urandom);
      end
      r = $urandom_range(0, 99);
      if (r < 60) lim = LIM_W'($urandom_range(1, 8));
      else if (r < 80) lim = LIM_W'($urandom_range(9, 40));
      else if (r < 90) lim = '0;
      else lim = LIM_W'($urandom);
      write_reg(REG_LOW_THR, lo);
      write_reg(REG_HIGH_THR, hi);
      write_reg(REG_LONG_LIMIT, {2'($urandom), lim});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
      run_presses(90, 2 * int'(lim) + 3, 10, 10);
    end
  endtask

  task automatic test_back_to_back();
    settle();
    write_reg(REG_LOW_THR, 12'd600);
    write_reg(REG_HIGH_THR, 12'd3400);
    write_reg(REG_LONG_LIMIT, 12'd4);
    quiet = 1'b1;
    run_presses(120, 11, 5, 10);
    quiet = 1'b0;
  endtask

  // one key held past the largest limit so its counter saturates
  task automatic test_max_limit();
    settle();
    write_reg(REG_LOW_THR, LOW_THR_RST);
    write_reg(REG_HIGH_THR, HIGH_THR_RST);
    write_reg(REG_LONG_LIMIT, 12'h3FF);
    chan_pos[0]  = KEY_LOW;
    chan_left[0] = 1030;
    run_presses(1070, 20, 0, 1);
  endtask

  // result side: random back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      res.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 20) begin
      res.ready <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    key_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("key result transfer with nothing expected");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res.short_press_mask !== want.short_press) begin
          $error("short_press_mask: expected %h, got %h", want.short_press,
                 res.short_press_mask);
          errors++;
        end
        if (res.long_hold_mask !== want.long_hold) begin
          $error("long_hold_mask: expected %h, got %h", want.long_hold, res.long_hold_mask);
          errors++;
        end
        if (res.pressed_mask !== want.pressed) begin
          $error("pressed_mask: expected %h, got %h", want.pressed, res.pressed_mask);
          errors++;
        end
      end
    end
  end

  initial begin
    smp.valid      = 1'b0;
    smp.scan_tick  = 1'b0;
    smp.sample_ch0 = '0;
    smp.sample_ch1 = '0;
    smp.sample_ch2 = '0;
    smp.sample_ch3 = '0;
    res.ready      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_thresholds();
    test_short_long();
    test_limit_edges();
    test_random_settings();
    test_back_to_back();
    test_max_limit();
    settle();
    if (errors == 0) begin
      $display("adc_key_short_long_press_core_tb: done, clean");
    end else begin
      $display("adc_key_short_long_press_core_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("adc_key_short_long_press_core_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/adckey_pkg.sv
src/adckey_if.sv
src/adckey_eval.sv
src/adc_key_short_long_press_core.sv
tb/sv/adc_key_short_long_press_core_tb.sv
